/* design/btrn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package btrn_pkg;

	localparam int VALUE_W     = 12;
	localparam int SYMBOL_W    = 7;
	localparam int DIGITS      = 4;
	localparam int DIGIT_W     = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [VALUE_W-1:0] VALUE_MIN = 12'd1;
	localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

	localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'd0;
	localparam logic [SYMBOL_W-1:0] SYM_I    = 7'd73;
	localparam logic [SYMBOL_W-1:0] SYM_V    = 7'd86;
	localparam logic [SYMBOL_W-1:0] SYM_X    = 7'd88;
	localparam logic [SYMBOL_W-1:0] SYM_L    = 7'd76;
	localparam logic [SYMBOL_W-1:0] SYM_C    = 7'd67;
	localparam logic [SYMBOL_W-1:0] SYM_D    = 7'd68;
	localparam logic [SYMBOL_W-1:0] SYM_M    = 7'd77;

	typedef struct packed {
		logic                            err;
		logic [DIGITS-1:0][DIGIT_W-1:0]  dig;
	} btrn_item_t;

	typedef enum logic [1:0] {
		FRONT_IDLE,
		FRONT_DIV,
		FRONT_PUSH
	} btrn_front_state_t;

	// characters in the numeral of one decimal digit
	function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
		logic [2:0] n;
		unique case (d)
			4'd0:    n = 3'd0;
			4'd1:    n = 3'd1;
			4'd2:    n = 3'd2;
			4'd3:    n = 3'd3;
			4'd4:    n = 3'd2;
			4'd5:    n = 3'd1;
			4'd6:    n = 3'd2;
			4'd7:    n = 3'd3;
			4'd8:    n = 3'd4;
			4'd9:    n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [SYMBOL_W-1:0] digit_char(input logic [1:0] pos,
		input logic [DIGIT_W-1:0] d, input logic [1:0] k);
		logic [SYMBOL_W-1:0] one;
		logic [SYMBOL_W-1:0] five;
		logic [SYMBOL_W-1:0] ten;
		logic [SYMBOL_W-1:0] c;
		unique case (pos)
			2'd3: begin one = SYM_M; five = SYM_NONE; ten = SYM_NONE; end
			2'd2: begin one = SYM_C; five = SYM_D;    ten = SYM_M;    end
			2'd1: begin one = SYM_X; five = SYM_L;    ten = SYM_C;    end
			default: begin one = SYM_I; five = SYM_V; ten = SYM_X;    end
		endcase
		if (d == 4'd4)
			c = (k == 2'd0) ? one : five;
		else if (d == 4'd9)
			c = (k == 2'd0) ? one : ten;
		else if (d >= 4'd5)
			c = (k == 2'd0) ? five : one;
		else
			c = one;
		return c;
	endfunction

	// highest position below limit holding a nonzero digit
	function automatic logic [1:0] next_nz(input logic [DIGITS-1:0][DIGIT_W-1:0] dig,
		input logic [2:0] limit);
		logic [1:0] p;
		p = 2'd0;
		for (int i = 0; i < DIGITS; i++) begin
			if (3'(i) < limit && dig[i] != '0)
				p = 2'(i);
		end
		return p;
	endfunction

	function automatic logic any_nz(input logic [DIGITS-1:0][DIGIT_W-1:0] dig,
		input logic [2:0] limit);
		logic a;
		a = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if (3'(i) < limit && dig[i] != '0)
				a = 1'b1;
		end
		return a;
	endfunction

endpackage

`default_nettype wire

/* design/btrn_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module btrn_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [btrn_pkg::VALUE_W-1:0]     value,
	output logic                             push_valid,
	input  wire                              push_ready,
	output btrn_pkg::btrn_item_t             push_item
);
	import btrn_pkg::*;

	btrn_front_state_t              state_q, state_d;
	logic [VALUE_W-1:0]             rem_q;
	logic [1:0]                     step_q;
	logic [DIGITS-1:0][DIGIT_W-1:0] dig_q;
	logic                           err_q;

	logic [VALUE_W+1:0]             weight;
	logic [DIGIT_W-1:0]             cnt;
	logic [VALUE_W+1:0]             sub;
	logic [VALUE_W-1:0]             rem_next;
	logic                           take;

	always_comb begin
		unique case (step_q)
			2'd0:    weight = 14'd1000;
			2'd1:    weight = 14'd100;
			default: weight = 14'd10;
		endcase
	end

	always_comb begin
		cnt = '0;
		for (int j = 1; j < 10; j++) begin
			if ({2'b00, rem_q} >= 14'(j) * weight)
				cnt = 4'(j);
		end
		sub      = 14'(cnt) * weight;
		rem_next = rem_q - sub[VALUE_W-1:0];
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		push_valid = 1'b0;
		take       = 1'b0;
		unique case (state_q)
			FRONT_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					take    = 1'b1;
					state_d = (value < VALUE_MIN || value > VALUE_MAX) ? FRONT_PUSH
						: FRONT_DIV;
				end
			end
			FRONT_DIV: begin
				if (step_q == 2'd2)
					state_d = FRONT_PUSH;
			end
			FRONT_PUSH: begin
				push_valid = 1'b1;
				if (push_ready)
					state_d = FRONT_IDLE;
			end
			default: state_d = FRONT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRONT_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (take)
				step_q <= '0;
			else if (state_q == FRONT_DIV)
				step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_q <= value;
			err_q <= (value < VALUE_MIN || value > VALUE_MAX);
		end else if (state_q == FRONT_DIV) begin
			dig_q[2'd3 - step_q] <= cnt;
			rem_q                <= rem_next;
			if (step_q == 2'd2)
				dig_q[0] <= rem_next[DIGIT_W-1:0];
		end
	end

	assign push_item.err = err_q;
	assign push_item.dig = dig_q;

endmodule

`default_nettype wire

/* design/btrn_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module btrn_fifo #(
	parameter int DEPTH = btrn_pkg::QUEUE_DEPTH
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push_valid,
	output logic                  push_ready,
	input  btrn_pkg::btrn_item_t  push_item,
	output logic                  pop_valid,
	input  wire                   pop_ready,
	output btrn_pkg::btrn_item_t  pop_item
);
	import btrn_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	btrn_item_t         mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push_item;
	end

endmodule

`default_nettype wire

/* design/btrn_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module btrn_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              pop_valid,
	output logic                             pop_ready,
	input  btrn_pkg::btrn_item_t             pop_item,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [btrn_pkg::SYMBOL_W-1:0]    symbol,
	output logic                             last,
	output logic                             error
);
	import btrn_pkg::*;

	logic                           busy_q;
	logic                           err_q;
	logic [DIGITS-1:0][DIGIT_W-1:0] dig_q;
	logic [1:0]                     pos_q;
	logic [1:0]                     k_q;

	logic                           out_valid_q;
	logic [SYMBOL_W-1:0]            symbol_q;
	logic                           last_q;
	logic                           error_q;

	logic [DIGIT_W-1:0]             cur_dig;
	logic                           dig_end;
	logic                           cur_last;
	logic [SYMBOL_W-1:0]            cur_sym;
	logic                           advance;

	assign cur_dig  = dig_q[pos_q];
	assign dig_end  = {1'b0, k_q} == digit_len(cur_dig) - 3'd1;
	assign cur_last = err_q || (dig_end && !any_nz(dig_q, {1'b0, pos_q}));
	assign cur_sym  = err_q ? SYM_NONE : digit_char(pos_q, cur_dig, k_q);
	assign advance  = busy_q && (!out_valid_q || out_ready);
	assign pop_ready = !busy_q || (advance && cur_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready)
				busy_q <= 1'b1;
			else if (advance && cur_last)
				busy_q <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			err_q <= pop_item.err;
			dig_q <= pop_item.dig;
			pos_q <= next_nz(pop_item.dig, 3'd4);
			k_q   <= '0;
		end else if (advance) begin
			if (dig_end) begin
				pos_q <= next_nz(dig_q, {1'b0, pos_q});
				k_q   <= '0;
			end else begin
				k_q <= k_q + 2'd1;
			end
		end
		if (advance) begin
			symbol_q <= cur_sym;
			last_q   <= cur_last;
			error_q  <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule

`default_nettype wire

/* design/binary_to_roman_numeral.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake             Payload
// input    in_valid / in_ready   value[11:0]
// output   out_valid / out_ready symbol[6:0], last, error
//
// The front takes a value, splits it into decimal digits from thousands down to units and
// hands it to the queue; an out-of-range value skips the split.
// The back sends one character per cycle while out_ready is held high, and sends an
// out-of-range value as one error beat.
// arst_n clears the sequencer, queue pointers and output valid; nothing is in flight.
// A stalled output holds the back; the queue lets the front keep taking values until it fills.

module binary_to_roman_numeral #(
	parameter int QUEUE_DEPTH = btrn_pkg::QUEUE_DEPTH
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [btrn_pkg::VALUE_W-1:0]     value,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [btrn_pkg::SYMBOL_W-1:0]    symbol,
	output logic                             last,
	output logic                             error
);
	import btrn_pkg::*;

	logic       push_valid;
	logic       push_ready;
	btrn_item_t push_item;
	logic       pop_valid;
	logic       pop_ready;
	btrn_item_t pop_item;

	btrn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	btrn_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	btrn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.symbol     (symbol),
		.last       (last),
		.error      (error)
	);

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> symbol == SYM_NONE && last)
		else $error("error beat carries a symbol or is not last");

	a_sym_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> symbol == SYM_I || symbol == SYM_V || symbol == SYM_X
			|| symbol == SYM_L || symbol == SYM_C || symbol == SYM_D || symbol == SYM_M)
		else $error("numeral beat with an illegal symbol");

	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("front took a value while converting");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import btrn_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_SHOWN   = 10;
	localparam int RUN_MAX     = 15;
	localparam int STEP_COUNT  = 13;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                last;
		logic                error;
	} char_beat_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [VALUE_W-1:0]  value;
	logic                out_valid;
	logic                out_ready;
	logic [SYMBOL_W-1:0] symbol;
	logic                last;
	logic                error;

	char_beat_t          expected_chars[$];
	char_beat_t          head_char;

	int unsigned         step_weight [STEP_COUNT] = '{1000, 900, 500, 400, 100, 90, 50, 40,
		10, 9, 5, 4, 1};
	logic [SYMBOL_W-1:0] step_first [STEP_COUNT] = '{SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X,
		SYM_L, SYM_X, SYM_X, SYM_I, SYM_V, SYM_I, SYM_I};
	logic [SYMBOL_W-1:0] step_second [STEP_COUNT] = '{SYM_NONE, SYM_M, SYM_NONE, SYM_D,
		SYM_NONE, SYM_C, SYM_NONE, SYM_L, SYM_NONE, SYM_X, SYM_NONE, SYM_V, SYM_NONE};

	int                  mismatches;
	int                  values_sent;
	int                  range_errors_sent;
	int                  chars_checked;
	int                  longest_run;
	int                  cycle_count;
	int                  hold_cycles;
	bit                  receiver_eager;
	logic [15:0]         ready_pattern;

	binary_to_roman_numeral uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.symbol    (symbol),
		.last      (last),
		.error     (error)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
		int unsigned rest;
		int n;
		logic [SYMBOL_W-1:0] run [RUN_MAX];
		rest = v;
		n = 0;
		if (v < VALUE_MIN || v > VALUE_MAX) begin
			expected_chars.push_back('{symbol: SYM_NONE, last: 1'b1, error: 1'b1});
			range_errors_sent++;
			return;
		end
		for (int s = 0; s < STEP_COUNT; s++) begin
			while (rest >= step_weight[s] && n < RUN_MAX) begin
				run[n] = step_first[s];
				n++;
				if (step_second[s] != SYM_NONE && n < RUN_MAX) begin
					run[n] = step_second[s];
					n++;
				end
				rest -= step_weight[s];
			end
		end
		for (int k = 0; k < n; k++)
			expected_chars.push_back('{symbol: run[k], last: (k == n - 1), error: 1'b0});
		if (n > longest_run)
			longest_run = n;
	endfunction

	function automatic void note_mismatch(input string what, input char_beat_t want);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t: %s: expected symbol=%0d last=%0b error=%0b, %s",
				$realtime, what, want.symbol, want.last, want.error,
				$sformatf("got symbol=%0d last=%0b error=%0b", symbol, last, error));
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			chars_checked++;
			if (expected_chars.size() == 0) begin
				note_mismatch("unexpected beat", '0);
			end else begin
				head_char = expected_chars.pop_front();
				if (symbol !== head_char.symbol || last !== head_char.last ||
					error !== head_char.error)
					note_mismatch("wrong beat", head_char);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d beats still expected", cycle_count,
				expected_chars.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		ready_pattern = 16'hffff;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				hold_cycles--;
			end else if (receiver_eager) begin
				out_ready = 1'b1;
			end else begin
				if (cycle_count % 64 == 0)
					ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
				out_ready = ready_pattern[0];
				ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
			end
		end
	end

	task automatic send_value(input logic [VALUE_W-1:0] v);
		value = v;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		predict_numeral(v);
		values_sent++;
		@(negedge clk);
	endtask

	task automatic sender_gap(input int cycles);
		in_valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (expected_chars.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		int digit_pool [5] = '{3, 4, 7, 8, 9};
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 10)
			return VALUE_W'($urandom_range(4000, 4095));
		if (r < 25)
			return VALUE_W'($urandom_range(1, 3) * 1000 + digit_pool[$urandom_range(0, 4)] * 100 +
				digit_pool[$urandom_range(0, 4)] * 10 + digit_pool[$urandom_range(0, 4)]);
		if (r < 35)
			return VALUE_W'($urandom_range(1, 99));
		return VALUE_W'($urandom_range(1, 3999));
	endfunction

	task automatic test_directed_values();
		int picks [24] = '{1, 4, 5, 9, 10, 40, 50, 90, 100, 400, 500, 900, 1000, 3999, 3888, 0,
			4000, 4095, 2048, 1994, 444, 999, 3000, 2741};
		receiver_eager = 1'b1;
		foreach (picks[i])
			send_value(VALUE_W'(picks[i]));
		wait_drained();
		receiver_eager = 1'b0;
		foreach (picks[i]) begin
			send_value(VALUE_W'(picks[i]));
			if ($urandom_range(0, 2) == 0)
				sender_gap($urandom_range(1, 6));
		end
		wait_drained();
	endtask

	task automatic test_random_bursts(input int count);
		int burst_left;
		bit steady;
		burst_left = 0;
		steady = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				steady = ($urandom_range(0, 4) == 0);
				if (!steady)
					sender_gap($urandom_range(1, 12));
			end
			send_value(pick_value());
			burst_left--;
			receiver_eager = steady;
		end
		receiver_eager = 1'b0;
		wait_drained();
	endtask

	task automatic test_output_hold_off();
		hold_cycles = 300;
		for (int i = 0; i < 20; i++)
			send_value((i % 4 == 0) ? 12'd3888 : pick_value());
		wait_drained();
		hold_cycles = $urandom_range(100, 200);
		for (int i = 0; i < 12; i++)
			send_value(pick_value());
		wait_drained();
	endtask

	task automatic test_drain_pauses();
		int burst;
		for (int p = 0; p < 6; p++) begin
			burst = $urandom_range(1, 5);
			for (int i = 0; i < burst; i++)
				send_value(pick_value());
			wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		hold_cycles = 0;
		receiver_eager = 1'b0;
		mismatches = 0;
		values_sent = 0;
		range_errors_sent = 0;
		chars_checked = 0;
		longest_run = 0;
		cycle_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_values();
		test_output_hold_off();
		test_drain_pauses();
		test_random_bursts(360);

		wait_drained();
		repeat (20) @(negedge clk);
		if (expected_chars.size() != 0) begin
			mismatches++;
			$display("%0d expected beats never arrived", expected_chars.size());
		end
		$display("Sent %0d values (%0d out of range), checked %0d characters", values_sent,
			range_errors_sent, chars_checked);
		$display("Longest numeral %0d characters; output held off while input kept coming",
			longest_run);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/btrn_pkg.sv
design/btrn_front.sv
design/btrn_fifo.sv
design/btrn_back.sv
design/binary_to_roman_numeral.sv
dv/tb_top.sv
